@@ rtl/hkr_pkg.sv @@
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared types, constants and mod-26 helper functions for the 2x2 Hill
// cipher key recovery pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hkr_pkg;

  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned PROD_W      = 10;
  localparam int unsigned SUM_W       = 11;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 24;

  localparam logic [LETTER_W-1:0] MODULUS     = 5'd26;
  localparam logic [SUM_W-1:0]    MODULUS_SQ  = 11'd676;
  localparam logic [RECIP_W-1:0]  RECIP_26    = 23'd2521;
  localparam int unsigned         RECIP_SHIFT = 16;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [PROD_W-1:0]   prod_t;

  typedef struct packed {
    letter_t r1c1;
    letter_t r1c0;
    letter_t r0c1;
    letter_t r0c0;
  } mat_t;

  typedef struct packed {
    prod_t r1c1;
    prod_t r1c0;
    prod_t r0c1;
    prod_t r0c0;
  } pmat_t;

  function automatic letter_t red_letter(input letter_t v);
    return (v >= MODULUS) ? letter_t'(v - MODULUS) : v;
  endfunction

  function automatic letter_t neg26(input letter_t v);
    return (v == '0) ? '0 : letter_t'(MODULUS - v);
  endfunction

  function automatic letter_t mod26(input logic [SUM_W-1:0] v);
    logic [RECIP_W-1:0] prod;
    logic [6:0]         quo;
    logic [SUM_W-1:0]   qm;
    prod = RECIP_W'(v) * RECIP_26;
    quo  = prod[RECIP_W-1:RECIP_SHIFT];
    qm   = SUM_W'(quo) * SUM_W'(MODULUS);
    return letter_t'(v - qm);
  endfunction

  function automatic letter_t unit_inv(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hill_key_recovery_2x2_mod26.sv @@
// ----------------------------------------------------------------------------
// hill_key_recovery_2x2_mod26
// Recovers a 2x2 Hill cipher key mod 26 from one known plaintext and
// ciphertext matrix pair.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      in_tvalid/tready   in_tdata[39:0]: P then C, 5b each
//   out_     master     out_tvalid/tready  out_tdata[23:0] key, out_tuser
//
// The datapath is seven register stages deep (s1 to s7), and a result is
// presented from the s7 registers; one item is accepted per cycle while no
// result waits on out_tready.
// Reset clears all stage valid bits; no item is in flight afterwards.
// When a result waits on out_tready the whole pipeline holds, and in_tready
// is low for that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_key_recovery_2x2_mod26
  import hkr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // plain_r0c0, plain_r0c1, plain_r1c0, plain_r1c1,
  // cipher_r0c0, cipher_r0c1, cipher_r1c0, cipher_r1c1
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // key_r0c0, key_r0c1, key_r1c0, key_r1c1, four zero bits
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // invertible
  output logic                       out_tuser
);

  logic    en;
  mat_t    plain_in, cipher_in;
  logic    det_vld, adj_vld, adj_ok;
  mat_t    det_plain, det_cipher, adj_cipher, adj_pinv, key;
  letter_t det_dinv;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign plain_in  = in_tdata[19:0];
  assign cipher_in = in_tdata[39:20];

  hkr_det u_det (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (in_tvalid),
    .plain_in   (plain_in),
    .cipher_in  (cipher_in),
    .vld_out    (det_vld),
    .plain_out  (det_plain),
    .cipher_out (det_cipher),
    .dinv_out   (det_dinv)
  );

  hkr_adj u_adj (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (det_vld),
    .plain_in   (det_plain),
    .cipher_in  (det_cipher),
    .dinv_in    (det_dinv),
    .vld_out    (adj_vld),
    .cipher_out (adj_cipher),
    .pinv_out   (adj_pinv),
    .inv_ok_out (adj_ok)
  );

  hkr_key u_key (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (adj_vld),
    .cipher_in  (adj_cipher),
    .pinv_in    (adj_pinv),
    .inv_ok_in  (adj_ok),
    .vld_out    (out_tvalid),
    .key_out    (key),
    .inv_ok_out (out_tuser)
  );

  assign out_tdata = {4'd0, key};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the pipeline is stalled");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero key for a singular plaintext");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (key.r0c0 < MODULUS && key.r0c1 < MODULUS &&
                    key.r1c0 < MODULUS && key.r1c1 < MODULUS))
    else $error("key letter out of range");

endmodule

`default_nettype wire

@@ rtl/hkr_det.sv @@
// ----------------------------------------------------------------------------
// hkr_det
// Stages one to three: reduces the letter codes, forms the two diagonal
// products and looks up the inverse of the plaintext determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_det
  import hkr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    vld_in,
  input  wire mat_t    plain_in,
  input  wire mat_t    cipher_in,
  output logic         vld_out,
  output mat_t         plain_out,
  output mat_t         cipher_out,
  output letter_t      dinv_out
);

  logic    s1_vld_r, s2_vld_r, s3_vld_r;
  mat_t    s1_plain_r, s1_cipher_r;
  mat_t    s2_plain_r, s2_cipher_r;
  mat_t    s3_plain_r, s3_cipher_r;
  prod_t   s2_pa_r, s2_pb_r;
  letter_t s3_dinv_r;

  mat_t    s1_plain_nxt, s1_cipher_nxt;
  letter_t det_nxt;

  always_comb begin
    s1_plain_nxt.r0c0  = red_letter(plain_in.r0c0);
    s1_plain_nxt.r0c1  = red_letter(plain_in.r0c1);
    s1_plain_nxt.r1c0  = red_letter(plain_in.r1c0);
    s1_plain_nxt.r1c1  = red_letter(plain_in.r1c1);
    s1_cipher_nxt.r0c0 = red_letter(cipher_in.r0c0);
    s1_cipher_nxt.r0c1 = red_letter(cipher_in.r0c1);
    s1_cipher_nxt.r1c0 = red_letter(cipher_in.r1c0);
    s1_cipher_nxt.r1c1 = red_letter(cipher_in.r1c1);
    det_nxt = mod26(SUM_W'(s2_pa_r) + MODULUS_SQ - SUM_W'(s2_pb_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_in;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_plain_r  <= s1_plain_nxt;
      s1_cipher_r <= s1_cipher_nxt;
      s2_plain_r  <= s1_plain_r;
      s2_cipher_r <= s1_cipher_r;
      s2_pa_r     <= PROD_W'(s1_plain_r.r0c0) * PROD_W'(s1_plain_r.r1c1);
      s2_pb_r     <= PROD_W'(s1_plain_r.r0c1) * PROD_W'(s1_plain_r.r1c0);
      s3_plain_r  <= s2_plain_r;
      s3_cipher_r <= s2_cipher_r;
      s3_dinv_r   <= unit_inv(det_nxt);
    end
  end

  assign vld_out    = s3_vld_r;
  assign plain_out  = s3_plain_r;
  assign cipher_out = s3_cipher_r;
  assign dinv_out   = s3_dinv_r;

endmodule

`default_nettype wire

@@ rtl/hkr_adj.sv @@
// ----------------------------------------------------------------------------
// hkr_adj
// Stages four and five: scales the adjugate of the plaintext matrix by the
// determinant inverse, giving the inverse plaintext matrix mod 26.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_adj
  import hkr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    vld_in,
  input  wire mat_t    plain_in,
  input  wire mat_t    cipher_in,
  input  wire letter_t dinv_in,
  output logic         vld_out,
  output mat_t         cipher_out,
  output mat_t         pinv_out,
  output logic         inv_ok_out
);

  logic  s4_vld_r, s5_vld_r;
  logic  s4_ok_r, s5_ok_r;
  mat_t  s4_cipher_r, s5_cipher_r;
  pmat_t s4_m_r;
  mat_t  s5_pinv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= vld_in;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_cipher_r  <= cipher_in;
      s4_ok_r      <= (dinv_in != '0);
      s4_m_r.r0c0  <= PROD_W'(plain_in.r1c1) * PROD_W'(dinv_in);
      s4_m_r.r0c1  <= PROD_W'(neg26(plain_in.r0c1)) * PROD_W'(dinv_in);
      s4_m_r.r1c0  <= PROD_W'(neg26(plain_in.r1c0)) * PROD_W'(dinv_in);
      s4_m_r.r1c1  <= PROD_W'(plain_in.r0c0) * PROD_W'(dinv_in);
      s5_cipher_r  <= s4_cipher_r;
      s5_ok_r      <= s4_ok_r;
      s5_pinv_r.r0c0 <= mod26(SUM_W'(s4_m_r.r0c0));
      s5_pinv_r.r0c1 <= mod26(SUM_W'(s4_m_r.r0c1));
      s5_pinv_r.r1c0 <= mod26(SUM_W'(s4_m_r.r1c0));
      s5_pinv_r.r1c1 <= mod26(SUM_W'(s4_m_r.r1c1));
    end
  end

  assign vld_out    = s5_vld_r;
  assign cipher_out = s5_cipher_r;
  assign pinv_out   = s5_pinv_r;
  assign inv_ok_out = s5_ok_r;

endmodule

`default_nettype wire

@@ rtl/hkr_key.sv @@
// ----------------------------------------------------------------------------
// hkr_key
// Stages six and seven: multiplies the ciphertext matrix by the inverse
// plaintext matrix and reduces the sums into the registered key.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_key
  import hkr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic vld_in,
  input  wire mat_t cipher_in,
  input  wire mat_t pinv_in,
  input  wire logic inv_ok_in,
  output logic      vld_out,
  output mat_t      key_out,
  output logic      inv_ok_out
);

  logic  s6_vld_r, s7_vld_r;
  logic  s6_ok_r, s7_ok_r;
  pmat_t s6_a_r, s6_b_r;
  mat_t  s7_key_r;
  mat_t  key_nxt;

  always_comb begin
    key_nxt.r0c0 = mod26(SUM_W'(s6_a_r.r0c0) + SUM_W'(s6_b_r.r0c0));
    key_nxt.r0c1 = mod26(SUM_W'(s6_a_r.r0c1) + SUM_W'(s6_b_r.r0c1));
    key_nxt.r1c0 = mod26(SUM_W'(s6_a_r.r1c0) + SUM_W'(s6_b_r.r1c0));
    key_nxt.r1c1 = mod26(SUM_W'(s6_a_r.r1c1) + SUM_W'(s6_b_r.r1c1));
    if (!s6_ok_r) begin
      key_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= vld_in;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ok_r     <= inv_ok_in;
      s6_a_r.r0c0 <= PROD_W'(cipher_in.r0c0) * PROD_W'(pinv_in.r0c0);
      s6_b_r.r0c0 <= PROD_W'(cipher_in.r0c1) * PROD_W'(pinv_in.r1c0);
      s6_a_r.r0c1 <= PROD_W'(cipher_in.r0c0) * PROD_W'(pinv_in.r0c1);
      s6_b_r.r0c1 <= PROD_W'(cipher_in.r0c1) * PROD_W'(pinv_in.r1c1);
      s6_a_r.r1c0 <= PROD_W'(cipher_in.r1c0) * PROD_W'(pinv_in.r0c0);
      s6_b_r.r1c0 <= PROD_W'(cipher_in.r1c1) * PROD_W'(pinv_in.r1c0);
      s6_a_r.r1c1 <= PROD_W'(cipher_in.r1c0) * PROD_W'(pinv_in.r0c1);
      s6_b_r.r1c1 <= PROD_W'(cipher_in.r1c1) * PROD_W'(pinv_in.r1c1);
      s7_ok_r     <= s6_ok_r;
      s7_key_r    <= key_nxt;
    end
  end

  assign vld_out    = s7_vld_r;
  assign key_out    = s7_key_r;
  assign inv_ok_out = s7_ok_r;

endmodule

`default_nettype wire
